>>> hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define BCU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define BCU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/bcu_pkg.sv
// Shared types, constants and BCD arithmetic functions of the complex accumulator.
package bcu_pkg;

  localparam int NumDigits  = 16;
  localparam int NormDigits = NumDigits + 1;
  localparam int NumW       = 4 * NumDigits;
  localparam int NormW      = 4 * NormDigits;
  localparam int CountW     = 5;
  localparam int CfgIdxW    = 1;
  localparam int TdataW     = 136;
  localparam int CmdW       = 2;

  localparam logic [CountW-1:0] CountReset = CountW'(NumDigits);

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] REG_REAL_COUNT = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_IMAG_COUNT = 1'b1;

  typedef logic [NormW-1:0] nbcd_t;

  localparam nbcd_t SixPat = {NormDigits{4'h6}};

  typedef enum logic [CmdW-1:0] {
    CMD_LOAD = 2'd0,
    CMD_ADD  = 2'd1,
    CMD_SUB  = 2'd2,
    CMD_HOLD = 2'd3
  } cmd_t;

  // One part of an operand, magnitude normalized to valid BCD
  typedef struct packed {
    logic  neg;
    nbcd_t mag;
  } part_t;

  // Operand stage status toward the accumulate stage
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } s1_ctrl_t;

  // Valid BCD add with carry in; returns {carry out, sum}
  function automatic logic [NormW:0] bcd_add(input nbcd_t x, input nbcd_t y, input logic cin);
    nbcd_t          t;
    logic [NormW:0] s;
    logic [NormW:0] cvec;
    nbcd_t          r;
    t    = x + SixPat;
    s    = {1'b0, t} + {1'b0, y} + {{NormW{1'b0}}, cin};
    cvec = {1'b0, t} ^ {1'b0, y} ^ s;
    for (int i = 0; i < NormDigits; i++) begin
      // a digit that produced no carry still holds the +6 bias
      r[4*i +: 4] = cvec[4*(i+1)] ? s[4*i +: 4] : s[4*i +: 4] - 4'd6;
    end
    return {s[NormW], r};
  endfunction

  // Nines complement, digit by digit
  function automatic nbcd_t nines(input nbcd_t y);
    nbcd_t r;
    for (int i = 0; i < NormDigits; i++) begin
      r[4*i +: 4] = 4'd9 - y[4*i +: 4];
    end
    return r;
  endfunction

  // Nibble mask of the kept digits; counts past the maximum saturate
  function automatic nbcd_t digit_mask(input logic [CountW-1:0] cnt);
    logic [CountW-1:0] eff;
    nbcd_t             m;
    eff = (cnt > CountW'(NumDigits)) ? CountW'(NumDigits) : cnt;
    for (int i = 0; i < NormDigits; i++) begin
      m[4*i +: 4] = (CountW'(i) < eff) ? 4'hF : 4'h0;
    end
    return m;
  endfunction

  // Turn nibbles of any value into valid BCD, one digit wider
  function automatic nbcd_t normalize(input logic [NumW-1:0] raw);
    nbcd_t          lo;
    nbcd_t          cv;
    logic [3:0]     d;
    logic [NormW:0] res;
    lo = '0;
    cv = '0;
    for (int i = 0; i < NumDigits; i++) begin
      d = raw[4*i +: 4];
      if (d > 4'd9) begin
        lo[4*i +: 4]     = d - 4'd10;
        cv[4*(i+1) +: 4] = 4'd1;
      end else begin
        lo[4*i +: 4] = d;
      end
    end
    res = bcd_add(lo, cv, 1'b0);
    return res[NormW-1:0];
  endfunction

endpackage

>>> hdl/bcu_in_stage.sv
// Operand stage: input transfer, digit-count masking and BCD normalization.
module bcu_in_stage (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [bcu_pkg::TdataW-1:0]        in_tdata,
  input  logic [bcu_pkg::CmdW-1:0]          in_tuser,
  input  logic [bcu_pkg::CountW-1:0]        real_cnt,
  input  logic [bcu_pkg::CountW-1:0]        imag_cnt,
  input  logic                              advance,
  output bcu_pkg::s1_ctrl_t                 ctrl,
  output bcu_pkg::part_t                    real_op,
  output bcu_pkg::part_t                    imag_op
);

  logic              valid_r, valid_nxt;
  bcu_pkg::cmd_t     cmd_r;
  bcu_pkg::part_t    real_r, imag_r;
  bcu_pkg::nbcd_t    real_mask, imag_mask;
  logic              in_fire;

  assign in_tready = !valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  assign real_mask = bcu_pkg::digit_mask(real_cnt);
  assign imag_mask = bcu_pkg::digit_mask(imag_cnt);

  // Stage occupancy
  always_comb begin
    if (in_fire) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Operand capture; digits above the count are dropped before normalizing
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r        <= bcu_pkg::cmd_t'(in_tuser);
      real_r.neg   <= in_tdata[0];
      real_r.mag   <= bcu_pkg::normalize(in_tdata[64:1] & real_mask[bcu_pkg::NumW-1:0]);
      imag_r.neg   <= in_tdata[65];
      imag_r.mag   <= bcu_pkg::normalize(in_tdata[129:66] & imag_mask[bcu_pkg::NumW-1:0]);
    end
  end

  assign ctrl.valid = valid_r;
  assign ctrl.cmd   = cmd_r;
  assign real_op    = real_r;
  assign imag_op    = imag_r;

endmodule

>>> hdl/bcu_part_acc.sv
// Accumulate stage for one part: sign-magnitude BCD add or subtract into the accumulator.
module bcu_part_acc (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  bcu_pkg::cmd_t                 cmd,
  input  bcu_pkg::part_t                op,
  input  logic [bcu_pkg::CountW-1:0]    cnt,
  output logic                          acc_neg,
  output logic [bcu_pkg::NumW-1:0]      acc_mag
);

  logic                          neg_r, neg_nxt;
  logic [bcu_pkg::NumW-1:0]      mag_r, mag_nxt;
  bcu_pkg::nbcd_t                mask, ma, mb, mr;
  logic                          sb, sr;
  logic [bcu_pkg::NormW:0]       sum_ab, dif_ab, dif_ba;

  assign mask = bcu_pkg::digit_mask(cnt);
  assign ma   = {4'h0, mag_r} & mask;
  assign mb   = op.mag;
  assign sb   = op.neg ^ (cmd == bcu_pkg::CMD_SUB);

  // All three magnitudes in parallel; carry out of a - b says a >= b
  assign sum_ab = bcu_pkg::bcd_add(ma, mb, 1'b0);
  assign dif_ab = bcu_pkg::bcd_add(ma, bcu_pkg::nines(mb), 1'b1);
  assign dif_ba = bcu_pkg::bcd_add(mb, bcu_pkg::nines(ma), 1'b1);

  always_comb begin
    unique case (cmd) inside
      bcu_pkg::CMD_LOAD: begin
        mr = mb;
        sr = op.neg;
      end
      bcu_pkg::CMD_ADD, bcu_pkg::CMD_SUB: begin
        if (neg_r == sb) begin
          mr = sum_ab[bcu_pkg::NormW-1:0];
          sr = neg_r;
        end else if (dif_ab[bcu_pkg::NormW]) begin
          mr = dif_ab[bcu_pkg::NormW-1:0];
          sr = neg_r;
        end else begin
          mr = dif_ba[bcu_pkg::NormW-1:0];
          sr = sb;
        end
      end
      default: begin
        mr = ma;
        sr = neg_r;
      end
    endcase
  end

  // Wrap to the kept digits; zero is always positive
  always_comb begin
    mag_nxt = mr[bcu_pkg::NumW-1:0] & mask[bcu_pkg::NumW-1:0];
    neg_nxt = sr && (mag_nxt != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neg_r <= 1'b0;
      mag_r <= '0;
    end else if (en) begin
      neg_r <= neg_nxt;
      mag_r <= mag_nxt;
    end
  end

  assign acc_neg = neg_r;
  assign acc_mag = mag_r;

endmodule

>>> hdl/bcd_complex_accumulate_unit.sv
// Top level of the complex sign-magnitude BCD accumulator.
//
//  port group  dir  tdata / tuser contents (lowest bit first)
//  in_*        in   tdata: real_negative, real_digits, imag_negative, imag_digits
//                   tuser: command
//  out_*       out  tdata: sum_real_negative, sum_real_digits,
//                          sum_imag_negative, sum_imag_digits
//  cfg_*       in   index 0 real_digit_count, index 1 imag_digit_count
//
// Two register stages: the operand stage masks and normalizes the operand,
// the accumulate stage does a 17-digit BCD add/subtract and its register is
// both the accumulator and the output register. One item per cycle unless stalled.
// An item may enter while a result waits as long as the operand stage is free.
// Synchronous active-low reset clears the accumulator, counts go to 16.
module bcd_complex_accumulate_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [bcu_pkg::TdataW-1:0]        in_tdata,   // real_negative, real_digits,
                                                        // imag_negative, imag_digits
  input  logic [bcu_pkg::CmdW-1:0]          in_tuser,   // command
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [bcu_pkg::TdataW-1:0]        out_tdata,  // sum_real_negative, sum_real_digits,
                                                        // sum_imag_negative, sum_imag_digits
  input  logic                              cfg_we,
  input  logic [bcu_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [bcu_pkg::CountW-1:0]        cfg_wdata
);

  logic [bcu_pkg::CountW-1:0]  real_cnt_r, imag_cnt_r;
  logic                        out_valid_r, out_valid_nxt;
  logic                        advance;
  logic                        acc_en;
  bcu_pkg::s1_ctrl_t           s1_ctrl;
  bcu_pkg::part_t              real_op, imag_op;
  logic                        real_neg, imag_neg;
  logic [bcu_pkg::NumW-1:0]    real_mag, imag_mag;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      real_cnt_r <= bcu_pkg::CountReset;
      imag_cnt_r <= bcu_pkg::CountReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bcu_pkg::REG_REAL_COUNT: real_cnt_r <= cfg_wdata;
        bcu_pkg::REG_IMAG_COUNT: imag_cnt_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Output register is free or being emptied
  assign advance = !out_valid_r || out_tready;
  assign acc_en  = advance && s1_ctrl.valid;

  always_comb begin
    out_valid_nxt = advance ? s1_ctrl.valid : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  bcu_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .real_cnt  (real_cnt_r),
    .imag_cnt  (imag_cnt_r),
    .advance   (advance),
    .ctrl      (s1_ctrl),
    .real_op   (real_op),
    .imag_op   (imag_op)
  );

  bcu_part_acc u_real_acc (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (acc_en),
    .cmd     (s1_ctrl.cmd),
    .op      (real_op),
    .cnt     (real_cnt_r),
    .acc_neg (real_neg),
    .acc_mag (real_mag)
  );

  bcu_part_acc u_imag_acc (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (acc_en),
    .cmd     (s1_ctrl.cmd),
    .op      (imag_op),
    .cnt     (imag_cnt_r),
    .acc_neg (imag_neg),
    .acc_mag (imag_mag)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, imag_mag, imag_neg, real_mag, real_neg};

endmodule

>>> hdl/bcu_checker.sv
// Port-level checker for the complex accumulator and its bind.
`include "assert_macros.svh"

module bcu_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [bcu_pkg::TdataW-1:0]    out_tdata
);

  logic out_stall;
  logic real_neg_zero;
  logic imag_neg_zero;

  assign out_stall     = out_tvalid && !out_tready;
  assign real_neg_zero = out_tdata[0] && (out_tdata[64:1] == '0);
  assign imag_neg_zero = out_tdata[65] && (out_tdata[129:66] == '0);

  // Nothing is shown the cycle after reset
  `BCU_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "result valid after reset")

  // A stalled result stays put
  `BCU_ASSERT(a_out_hold, out_stall |=> out_tvalid && $stable(out_tdata), "stalled result changed")

  // With the output register empty the block must take input
  `BCU_ASSERT(a_ready_when_empty, !out_tvalid |-> in_tready, "input blocked with empty output")

  // A zero magnitude never carries a minus sign
  `BCU_ASSERT(a_zero_pos, out_tvalid |-> !real_neg_zero && !imag_neg_zero, "negative zero")

endmodule

bind bcd_complex_accumulate_unit bcu_checker u_bcu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
